/* hdl/bhhd_pkg.sv */
// Shared types, codes and reset constants for the selection box handle block.
package bhhd_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int SHAPE_KIND_RST   = 0;
  localparam int MOVE_LIMIT_X_RST = 1994;
  localparam int MOVE_LIMIT_Y_RST = 1995;
  localparam int RESIZE_LIMIT_RST = 1990;

  localparam int HIT_MARGIN = 4;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_START  = 3'd1,
    OP_END    = 3'd2,
    OP_HIT    = 3'd3,
    OP_GRAB   = 3'd4,
    OP_MOVE   = 3'd5,
    OP_RESIZE = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    REG_SHAPE_KIND   = 2'd0,
    REG_MOVE_LIMIT_X = 2'd1,
    REG_MOVE_LIMIT_Y = 2'd2,
    REG_RESIZE_LIMIT = 2'd3
  } reg_addr_t;

  // Handle codes, shared by the hit test result and the resize mode.
  localparam logic [3:0] HND_NONE         = 4'd0;
  localparam logic [3:0] HND_TOP_LEFT     = 4'd1;
  localparam logic [3:0] HND_BOTTOM_RIGHT = 4'd2;
  localparam logic [3:0] HND_TOP_RIGHT    = 4'd3;
  localparam logic [3:0] HND_BOTTOM_LEFT  = 4'd4;
  localparam logic [3:0] HND_LEFT         = 4'd5;
  localparam logic [3:0] HND_RIGHT        = 4'd6;
  localparam logic [3:0] HND_TOP          = 4'd7;
  localparam logic [3:0] HND_BOTTOM       = 4'd8;
  localparam logic [3:0] HND_EDGE         = 4'd9;

  // Shape kinds that make the box edge itself a hit target.
  localparam logic [3:0] SHAPE_EDGE_A = 4'd1;
  localparam logic [3:0] SHAPE_EDGE_B = 4'd3;

endpackage

/* hdl/box_handle_hit_and_drag_top.sv */
// Selection box with handle hit test, grab, move and resize.
// An accepted request waits in the input register and moves to the result register when
// the output is free. Throughput: one request per cycle while the output is not stalled;
// each request is done in the single stage between the input register and the result
// register, where the box state is also updated.
// Reset (rst, synchronous): clears the box, grab data and both pipeline valids, and
// loads the configuration registers with their defaults.
module box_handle_hit_and_drag_top #(
  parameter int COORD_BITS = bhhd_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // pos_x, pos_y, scroll_x, scroll_y, handle_mode (from bit 0 up), zero padded
  input  logic [((4*COORD_BITS+2+7)/8)*8-1:0]        s_tdata,
  // op
  input  logic [2:0]                                 s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // handle, begin_x, begin_y, end_x, end_y (from bit 0 up), zero padded
  output logic [((4*COORD_BITS+8+7)/8)*8-1:0]        m_tdata,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [3:0]                                 paddr,
  input  logic [31:0]                                pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  localparam int CORNER_BITS   = COORD_BITS + 1;
  localparam int W             = COORD_BITS + 5;
  localparam int OUT_DATA_BITS = ((4*COORD_BITS+8+7)/8)*8;

  localparam logic signed [W-1:0] CORNER_MAX = W'((1 << COORD_BITS) - 1);
  localparam logic signed [W-1:0] CORNER_MIN = W'(-(1 << COORD_BITS));
  localparam logic signed [W-1:0] ONE        = W'(1);
  localparam logic signed [W-1:0] MARGIN     = W'(bhhd_pkg::HIT_MARGIN);

  // Configuration registers.
  logic [3:0]            shape_kind;
  logic [COORD_BITS-1:0] move_limit_x;
  logic [COORD_BITS-1:0] move_limit_y;
  logic [COORD_BITS-1:0] resize_limit;

  // Input register.
  logic                          in_valid;
  bhhd_pkg::op_t                 in_op;
  logic signed [COORD_BITS-1:0]  in_pos_x;
  logic signed [COORD_BITS-1:0]  in_pos_y;
  logic [COORD_BITS-2:0]         in_scroll_x;
  logic [COORD_BITS-2:0]         in_scroll_y;
  logic [3:0]                    in_mode;

  // Box state.
  logic signed [CORNER_BITS-1:0] corner_begin_x, corner_begin_y;
  logic signed [CORNER_BITS-1:0] corner_end_x, corner_end_y;
  logic signed [COORD_BITS-1:0]  grab_mouse_x, grab_mouse_y;
  logic signed [CORNER_BITS-1:0] saved_begin_x, saved_begin_y;
  logic signed [CORNER_BITS-1:0] saved_end_x, saved_end_y;

  logic signed [CORNER_BITS-1:0] corner_begin_x_next, corner_begin_y_next;
  logic signed [CORNER_BITS-1:0] corner_end_x_next, corner_end_y_next;
  logic [3:0]                    handle_next;

  // Result register; the corners of the result are the box state itself.
  logic       out_valid;
  logic [3:0] out_handle;

  logic advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_BITS'({corner_end_y, corner_end_x, corner_begin_y,
                                    corner_begin_x, out_handle});
  assign pready   = 1'b1;

  function automatic logic signed [CORNER_BITS-1:0] sat_corner(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    begin
      r = v;
      if (v > CORNER_MAX) r = CORNER_MAX;
      if (v < CORNER_MIN) r = CORNER_MIN;
      sat_corner = r[CORNER_BITS-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] half_toward_zero(input logic signed [W-1:0] s);
    logic signed [W-1:0] t;
    begin
      t = s + signed'(W'(s[W-1]));
      half_toward_zero = t >>> 1;
    end
  endfunction

  always_comb begin
    logic signed [W-1:0] mx, my, gx, gy, dx, dy;
    logic signed [W-1:0] cbx, cby, cex, cey;
    logic signed [W-1:0] top, left, bot, right, midx, midy;
    logic signed [W-1:0] bx, by, ex, ey, lx, ly, lim;
    logic signed [W-1:0] bdx, bdy, edx, edy;
    logic at_left, at_right, at_top, at_bot, at_midx, at_midy, outside;
    logic resize_ok;

    mx  = W'(in_pos_x);
    my  = W'(in_pos_y);
    gx  = W'(grab_mouse_x);
    gy  = W'(grab_mouse_y);
    dx  = mx - gx;
    dy  = my - gy;
    cbx = W'(corner_begin_x);
    cby = W'(corner_begin_y);
    cex = W'(corner_end_x);
    cey = W'(corner_end_y);
    lx  = signed'(W'(move_limit_x));
    ly  = signed'(W'(move_limit_y));
    lim = signed'(W'(resize_limit));

    // Hit test geometry.
    top   = (cby < cey) ? cby : cey;
    bot   = (cby > cey) ? cby : cey;
    left  = (cbx < cex) ? cbx : cex;
    right = (cbx > cex) ? cbx : cex;
    midy  = half_toward_zero(bot + top);
    midx  = half_toward_zero(right + left);
    at_left  = (mx >= left - MARGIN) && (mx <= left + ONE);
    at_right = (mx >= right - ONE) && (mx <= right + MARGIN);
    at_top   = (my >= top - MARGIN) && (my <= top + ONE);
    at_bot   = (my >= bot - ONE) && (my <= bot + MARGIN);
    at_midy  = (my >= midy - W'(3)) && (my <= midy + W'(2));
    at_midx  = (mx >= midx - W'(3)) && (mx <= midx + W'(2));
    outside  = (my < top - MARGIN) || (my > bot + MARGIN) ||
               (mx < left - MARGIN) || (mx > right + MARGIN);

    bx = '0; by = '0; ex = '0; ey = '0;
    bdx = '0; bdy = '0; edx = '0; edy = '0;
    resize_ok = 1'b1;

    handle_next         = bhhd_pkg::HND_NONE;
    corner_begin_x_next = corner_begin_x;
    corner_begin_y_next = corner_begin_y;
    corner_end_x_next   = corner_end_x;
    corner_end_y_next   = corner_end_y;

    case (in_op)
      bhhd_pkg::OP_CLEAR: begin
        corner_begin_x_next = '0;
        corner_begin_y_next = '0;
        corner_end_x_next   = '0;
        corner_end_y_next   = '0;
      end
      bhhd_pkg::OP_START: begin
        corner_begin_x_next = CORNER_BITS'(in_pos_x);
        corner_end_x_next   = CORNER_BITS'(in_pos_x);
        corner_begin_y_next = CORNER_BITS'(in_pos_y);
        corner_end_y_next   = CORNER_BITS'(in_pos_y);
      end
      bhhd_pkg::OP_END: begin
        corner_end_x_next = sat_corner(mx + signed'(W'(in_scroll_x)));
        corner_end_y_next = sat_corner(my + signed'(W'(in_scroll_y)));
      end
      bhhd_pkg::OP_HIT: begin
        if (outside) begin
          handle_next = bhhd_pkg::HND_NONE;
        end else if (at_top && at_left) begin
          handle_next = bhhd_pkg::HND_TOP_LEFT;
        end else if (at_right && at_bot) begin
          handle_next = bhhd_pkg::HND_BOTTOM_RIGHT;
        end else if (at_left && at_bot) begin
          handle_next = bhhd_pkg::HND_BOTTOM_LEFT;
        end else if (at_right && at_top) begin
          handle_next = bhhd_pkg::HND_TOP_RIGHT;
        end else if (at_left && at_midy) begin
          handle_next = bhhd_pkg::HND_LEFT;
        end else if (at_right && at_midy) begin
          handle_next = bhhd_pkg::HND_RIGHT;
        end else if (at_midx && at_top) begin
          handle_next = bhhd_pkg::HND_TOP;
        end else if (at_midx && at_bot) begin
          handle_next = bhhd_pkg::HND_BOTTOM;
        end else if ((shape_kind == bhhd_pkg::SHAPE_EDGE_A ||
                      shape_kind == bhhd_pkg::SHAPE_EDGE_B) &&
                     ((((mx >= left - ONE) && (mx <= left + ONE)) ||
                       ((mx >= right - ONE) && (mx <= right + ONE))) &&
                      (my > top) && (my < bot) ||
                      (((my >= top - ONE) && (my <= top + ONE)) ||
                       ((my >= bot - ONE) && (my <= bot + ONE))) &&
                      (mx > left) && (mx < right))) begin
          handle_next = bhhd_pkg::HND_EDGE;
        end
      end
      bhhd_pkg::OP_MOVE: begin
        bx = W'(saved_begin_x) + dx;
        by = W'(saved_begin_y) + dy;
        ex = W'(saved_end_x) + dx;
        ey = W'(saved_end_y) + dy;
        // On each axis the begin corner is pushed above zero first; only otherwise is the end
        // corner pulled back to the limit.
        if (bx < ONE) begin
          ex = ex + ONE - bx;
          bx = ONE;
        end else if (ex > lx) begin
          bx = bx + lx - ex;
          ex = lx;
        end
        if (by < ONE) begin
          ey = ey + ONE - by;
          by = ONE;
        end else if (ey > ly) begin
          by = by + ly - ey;
          ey = ly;
        end
        corner_begin_x_next = sat_corner(bx);
        corner_begin_y_next = sat_corner(by);
        corner_end_x_next   = sat_corner(ex);
        corner_end_y_next   = sat_corner(ey);
      end
      bhhd_pkg::OP_RESIZE: begin
        case (in_mode)
          bhhd_pkg::HND_TOP_LEFT: begin
            bdx = dx;
            bdy = dy;
          end
          bhhd_pkg::HND_BOTTOM_RIGHT: begin
            edx = dx;
            edy = dy;
          end
          bhhd_pkg::HND_TOP_RIGHT: begin
            edx = dx;
            bdy = dy;
          end
          bhhd_pkg::HND_BOTTOM_LEFT: begin
            bdx = dx;
            edy = dy;
          end
          bhhd_pkg::HND_LEFT:   bdx = dx;
          bhhd_pkg::HND_RIGHT:  edx = dx;
          bhhd_pkg::HND_TOP:    bdy = dy;
          bhhd_pkg::HND_BOTTOM: edy = dy;
          default:              resize_ok = 1'b0;
        endcase
        // When the saved box is mirrored on an axis, the deltas swap corners.
        if (saved_begin_x < saved_end_x) begin
          bx = W'(saved_begin_x) + bdx;
          ex = W'(saved_end_x) + edx;
        end else begin
          bx = W'(saved_begin_x) + edx;
          ex = W'(saved_end_x) + bdx;
        end
        if (saved_begin_y < saved_end_y) begin
          by = W'(saved_begin_y) + bdy;
          ey = W'(saved_end_y) + edy;
        end else begin
          by = W'(saved_begin_y) + edy;
          ey = W'(saved_end_y) + bdy;
        end
        if (ex > lim) ex = lim;
        if (ey > lim) ey = lim;
        if (bx < ONE) bx = ONE;
        if (by < ONE) by = ONE;
        if (bx > lim) bx = lim;
        if (by > lim) by = lim;
        if (ex < ONE) ex = ONE;
        if (ey < ONE) ey = ONE;
        if (resize_ok) begin
          corner_begin_x_next = sat_corner(bx);
          corner_begin_y_next = sat_corner(by);
          corner_end_x_next   = sat_corner(ex);
          corner_end_y_next   = sat_corner(ey);
        end
      end
      default: begin
        handle_next = bhhd_pkg::HND_NONE;
      end
    endcase
  end

  always_comb begin
    prdata = '0;
    case (bhhd_pkg::reg_addr_t'(paddr[3:2]))
      bhhd_pkg::REG_SHAPE_KIND:   prdata = 32'(shape_kind);
      bhhd_pkg::REG_MOVE_LIMIT_X: prdata = 32'(move_limit_x);
      bhhd_pkg::REG_MOVE_LIMIT_Y: prdata = 32'(move_limit_y);
      bhhd_pkg::REG_RESIZE_LIMIT: prdata = 32'(resize_limit);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind     <= 4'(bhhd_pkg::SHAPE_KIND_RST);
      move_limit_x   <= COORD_BITS'(bhhd_pkg::MOVE_LIMIT_X_RST);
      move_limit_y   <= COORD_BITS'(bhhd_pkg::MOVE_LIMIT_Y_RST);
      resize_limit   <= COORD_BITS'(bhhd_pkg::RESIZE_LIMIT_RST);
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      corner_begin_x <= '0;
      corner_begin_y <= '0;
      corner_end_x   <= '0;
      corner_end_y   <= '0;
      grab_mouse_x   <= '0;
      grab_mouse_y   <= '0;
      saved_begin_x  <= '0;
      saved_begin_y  <= '0;
      saved_end_x    <= '0;
      saved_end_y    <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (bhhd_pkg::reg_addr_t'(paddr[3:2]))
          bhhd_pkg::REG_SHAPE_KIND:   shape_kind   <= pwdata[3:0];
          bhhd_pkg::REG_MOVE_LIMIT_X: move_limit_x <= pwdata[COORD_BITS-1:0];
          bhhd_pkg::REG_MOVE_LIMIT_Y: move_limit_y <= pwdata[COORD_BITS-1:0];
          bhhd_pkg::REG_RESIZE_LIMIT: resize_limit <= pwdata[COORD_BITS-1:0];
          default:                    shape_kind   <= shape_kind;
        endcase
      end

      if (s_tready) begin
        in_valid <= s_tvalid;
      end

      if (advance) begin
        out_valid      <= 1'b1;
        corner_begin_x <= corner_begin_x_next;
        corner_begin_y <= corner_begin_y_next;
        corner_end_x   <= corner_end_x_next;
        corner_end_y   <= corner_end_y_next;
        if (in_op == bhhd_pkg::OP_GRAB) begin
          grab_mouse_x  <= in_pos_x;
          grab_mouse_y  <= in_pos_y;
          saved_begin_x <= corner_begin_x;
          saved_begin_y <= corner_begin_y;
          saved_end_x   <= corner_end_x;
          saved_end_y   <= corner_end_y;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op       <= bhhd_pkg::op_t'(s_tuser);
      in_pos_x    <= s_tdata[COORD_BITS-1:0];
      in_pos_y    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      in_scroll_x <= s_tdata[3*COORD_BITS-2:2*COORD_BITS];
      in_scroll_y <= s_tdata[4*COORD_BITS-3:3*COORD_BITS-1];
      in_mode     <= s_tdata[4*COORD_BITS+1:4*COORD_BITS-2];
    end
    if (advance) begin
      out_handle <= handle_next;
    end
  end

endmodule

/* hdl/bhhd_checker.sv */
// Port-level checks for the selection box block, bound to its top level.
module bhhd_checker #(
  parameter int COORD_BITS = bhhd_pkg::COORD_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [((4*COORD_BITS+8+7)/8)*8-1:0] m_tdata,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [3:0]                          paddr,
  input logic [31:0]                         pwdata,
  input logic [31:0]                         prdata,
  input logic                                pready
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The hit code never goes past the edge code.
  a_handle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= bhhd_pkg::HND_EDGE)
    else $error("hit code out of range");

  // Input is only held off while a finished result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with no waiting result");

  // A write of the shape kind reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready &&
    paddr[3:2] == bhhd_pkg::REG_SHAPE_KIND
    |=> (paddr[3:2] != bhhd_pkg::REG_SHAPE_KIND) || (prdata[3:0] == $past(pwdata[3:0])))
    else $error("shape kind readback mismatch");

endmodule

bind box_handle_hit_and_drag_top bhhd_checker #(.COORD_BITS(COORD_BITS)) u_bhhd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready)
);
